FILE: rtl/vfd_modbus_frame_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the drive frame engine
// Every macro uses the clk and rst of the module that includes this file.
// ----------------------------------------------------------------------------
`ifndef VFD_MODBUS_FRAME_ENGINE_ASSERT_SVH
`define VFD_MODBUS_FRAME_ENGINE_ASSERT_SVH

// Condition that holds at every clock edge outside reset
`define VFE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define VFE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define VFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vfe_pkg.sv
// ----------------------------------------------------------------------------
// vfe_pkg
// Types, codes, constants and the CRC-16 byte step of the drive frame engine.
// ----------------------------------------------------------------------------
package vfe_pkg;

  // Input function codes
  localparam logic [2:0] FUNC_READ  = 3'd0;
  localparam logic [2:0] FUNC_SETF  = 3'd1;
  localparam logic [2:0] FUNC_START = 3'd2;
  localparam logic [2:0] FUNC_STOP  = 3'd3;
  localparam logic [2:0] FUNC_RX    = 3'd4;

  // Result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // CRC-16 (reflected 0x8005)
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Frame bytes
  localparam logic [7:0] FC_READ     = 8'h04;
  localparam logic [7:0] FC_WRITE    = 8'h05;
  localparam logic [7:0] FC_CTRL     = 8'h03;
  localparam logic [7:0] BYTE_ONE    = 8'h01;
  localparam logic [7:0] BYTE_TWO    = 8'h02;
  localparam logic [7:0] READ_REG    = 8'h03;
  localparam logic [7:0] CMD_RUN     = 8'h01;
  localparam logic [7:0] CMD_STOP    = 8'h08;

  // Expected reply lengths
  localparam logic [3:0] REPLY_LEN_READ = 4'd8;
  localparam logic [3:0] REPLY_LEN_SETF = 4'd7;
  localparam logic [3:0] REPLY_LEN_CTRL = 4'd6;

  // Body lengths of request frames (before the two CRC bytes)
  localparam logic [2:0] BODY_LEN_SETF = 3'd5;
  localparam logic [2:0] BODY_LEN_CTRL = 3'd4;

  // Reply byte positions
  localparam logic [3:0] RX_POS_ADDR = 4'd0;
  localparam logic [3:0] RX_POS_VHI  = 4'd4;
  localparam logic [3:0] RX_POS_VLO  = 4'd5;

  // speed*100/60 = floor(speed*5/3); saturates above this speed.
  // Below it, floor(speed*5/3) = (speed * 5*ceil(2^21/3)) >> 21 exactly.
  localparam logic [19:0] SPEED_SAT_LIMIT = 20'd39321;
  localparam logic [21:0] FREQ_MULT       = 22'd3495255;
  localparam int          FREQ_SHIFT      = 21;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'h01;

  // Command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    OP_READ,
    OP_SETF,
    OP_START,
    OP_STOP,
    OP_RX
  } op_t;

  // Classified command: frequency for set-frequency, byte for a received byte
  typedef struct packed {
    op_t         op;
    logic [15:0] data;
  } q_entry_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        crc_ok;
    logic        addr_ok;
    logic [15:0] reply_value;
  } rsp_t;

  // One byte through the CRC, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/vfe_if.sv
// ----------------------------------------------------------------------------
// Channel interfaces
// Command, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vfe_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [19:0] speed_rpm;
  logic [7:0]  rx_byte;

  modport source (output valid, func, speed_rpm, rx_byte, input ready);
  modport sink   (input valid, func, speed_rpm, rx_byte, output ready);
endinterface

interface vfe_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic        crc_ok;
  logic        addr_ok;
  logic [15:0] reply_value;

  modport source (output valid, kind, tx_byte, last, crc_ok, addr_ok, reply_value,
                  input ready);
  modport sink   (input valid, kind, tx_byte, last, crc_ok, addr_ok, reply_value,
                  output ready);
endinterface

interface vfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] slave_address;

  modport source (output valid, slave_address, input ready);
  modport sink   (input valid, slave_address, output ready);
endinterface

FILE: rtl/vfe_front.sv
// ----------------------------------------------------------------------------
// vfe_front
// Accepts commands, drops unused codes, converts speed to frequency and
// registers the classified command for the queue.
// ----------------------------------------------------------------------------
module vfe_front (
  input  logic            clk,
  input  logic            rst,
  vfe_cmd_if.sink         cmd,
  output vfe_pkg::q_entry_t ent,
  output logic            ent_valid,
  input  logic            ent_ready
);

  logic              fv;
  vfe_pkg::q_entry_t fent;
  vfe_pkg::q_entry_t cls;
  logic              keep;
  logic [37:0]       prod;
  logic [15:0]       freq;

  // Stage advances whenever it is empty or the queue takes its entry
  assign cmd.ready = !fv || ent_ready;
  assign ent       = fent;
  assign ent_valid = fv;

  // Frequency: floor(speed*5/3) via reciprocal, saturated to 16 bits
  assign prod = 38'(cmd.speed_rpm[15:0]) * 38'(vfe_pkg::FREQ_MULT);
  assign freq = (cmd.speed_rpm > vfe_pkg::SPEED_SAT_LIMIT) ? 16'hFFFF
              : prod[vfe_pkg::FREQ_SHIFT +: 16];

  // Classify
  always_comb begin
    keep     = 1'b1;
    cls.op   = vfe_pkg::OP_RX;
    cls.data = {8'h00, cmd.rx_byte};
    unique case (cmd.func)
      vfe_pkg::FUNC_READ:  cls.op = vfe_pkg::OP_READ;
      vfe_pkg::FUNC_SETF: begin
        cls.op   = vfe_pkg::OP_SETF;
        cls.data = freq;
      end
      vfe_pkg::FUNC_START: cls.op = vfe_pkg::OP_START;
      vfe_pkg::FUNC_STOP:  cls.op = vfe_pkg::OP_STOP;
      vfe_pkg::FUNC_RX:    cls.op = vfe_pkg::OP_RX;
      default:             keep   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (cmd.ready) begin
      fv <= cmd.valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      fent <= cls;
    end
  end

endmodule

FILE: rtl/vfe_fifo.sv
// ----------------------------------------------------------------------------
// vfe_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module vfe_fifo (
  input  logic              clk,
  input  logic              rst,
  input  vfe_pkg::q_entry_t din,
  input  logic              wr_valid,
  output logic              wr_ready,
  output vfe_pkg::q_entry_t dout,
  output logic              rd_valid,
  input  logic              rd_ready
);

  vfe_pkg::q_entry_t             mem [vfe_pkg::QDEPTH];
  logic [vfe_pkg::QPTR_W-1:0]    wr_ptr;
  logic [vfe_pkg::QPTR_W-1:0]    rd_ptr;
  logic [vfe_pkg::QPTR_W:0]      count;
  logic                          push;
  logic                          pop;

  assign wr_ready = (count != (vfe_pkg::QPTR_W + 1)'(vfe_pkg::QDEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign dout     = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/vfe_back.sv
// ----------------------------------------------------------------------------
// vfe_back
// Executes queued commands: sends request frames with CRC one byte a cycle
// while rsp is ready, tracks the reply receiver and raises the reply report.
// ----------------------------------------------------------------------------
`include "vfd_modbus_frame_engine_assert.svh"

module vfe_back (
  input  logic              clk,
  input  logic              rst,
  input  vfe_pkg::q_entry_t q,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [7:0]        addr,
  vfe_rsp_if.source         rsp
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t         st;
  vfe_pkg::op_t   cur_op;
  logic [15:0]    freq;
  logic [2:0]     k;
  logic [15:0]    tx_crc;

  logic           ov;
  vfe_pkg::rsp_t  opay;
  logic           load;
  logic           pop;

  logic [3:0]     exp_len;
  logic [3:0]     rx_count;
  logic [15:0]    rx_crc;
  logic           rx_match;
  logic [7:0]     vh;
  logic [7:0]     vl;

  logic [2:0]     nbody;
  logic [7:0]     body;
  logic [7:0]     tx_sel;
  logic           tx_last;

  logic [7:0]     rx_b;
  logic           rx_take;
  logic [15:0]    rx_crc_n;
  logic [3:0]     rx_cnt_n;
  logic           rx_match_n;
  logic [7:0]     vh_n;
  logic [7:0]     vl_n;
  logic           report;

  logic           req_pop;
  logic           tx_end;
  logic           idx_ok;

  // Output register frees when empty or taken
  assign load    = !ov || rsp.ready;
  assign pop     = (st == ST_IDLE) && load && q_valid;
  assign q_ready = pop;

  assign rsp.valid       = ov;
  assign rsp.kind        = opay.kind;
  assign rsp.tx_byte     = opay.tx_byte;
  assign rsp.last        = opay.last;
  assign rsp.crc_ok      = opay.crc_ok;
  assign rsp.addr_ok     = opay.addr_ok;
  assign rsp.reply_value = opay.reply_value;

  // Body byte of the current request frame
  assign nbody = (cur_op == vfe_pkg::OP_SETF) ? vfe_pkg::BODY_LEN_SETF
               : vfe_pkg::BODY_LEN_CTRL;

  always_comb begin
    case (k)
      3'd0: body = addr;
      3'd1: body = (cur_op == vfe_pkg::OP_READ) ? vfe_pkg::FC_READ
                 : (cur_op == vfe_pkg::OP_SETF) ? vfe_pkg::FC_WRITE
                 : vfe_pkg::FC_CTRL;
      3'd2: body = (cur_op == vfe_pkg::OP_SETF) ? vfe_pkg::BYTE_TWO : vfe_pkg::BYTE_ONE;
      3'd3: body = (cur_op == vfe_pkg::OP_SETF)  ? freq[15:8]
                 : (cur_op == vfe_pkg::OP_READ)  ? vfe_pkg::READ_REG
                 : (cur_op == vfe_pkg::OP_START) ? vfe_pkg::CMD_RUN
                 : vfe_pkg::CMD_STOP;
      3'd4: body = freq[7:0];
      default: body = 8'h00;
    endcase
  end

  // Body bytes, then CRC low, then CRC high
  assign tx_sel  = (k < nbody) ? body : (k == nbody) ? tx_crc[7:0] : tx_crc[15:8];
  assign tx_last = (k == nbody + 3'd1);

  // Receiver step for one reply byte
  assign rx_b       = q.data[7:0];
  assign rx_take    = (rx_count < exp_len);
  assign rx_crc_n   = vfe_pkg::crc_byte(rx_crc, rx_b);
  assign rx_cnt_n   = rx_count + 4'd1;
  assign rx_match_n = (rx_count == vfe_pkg::RX_POS_ADDR) ? (rx_b == addr) : rx_match;
  assign vh_n       = (rx_count == vfe_pkg::RX_POS_VHI) ? rx_b : vh;
  assign vl_n       = (rx_count == vfe_pkg::RX_POS_VLO) ? rx_b : vl;
  assign report     = rx_take && (rx_cnt_n == exp_len);

  // Sequencer, receiver state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      ov       <= 1'b0;
      exp_len  <= vfe_pkg::REPLY_LEN_READ;
      rx_count <= '0;
      rx_crc   <= vfe_pkg::CRC_INIT;
      rx_match <= 1'b0;
      vh       <= '0;
      vl       <= '0;
    end else begin
      unique case (st)
        ST_SEND: begin
          if (load) begin
            ov                <= 1'b1;
            opay.kind         <= vfe_pkg::KIND_TX;
            opay.tx_byte      <= tx_sel;
            opay.last         <= tx_last;
            opay.crc_ok       <= 1'b0;
            opay.addr_ok      <= 1'b0;
            opay.reply_value  <= '0;
            if (k < nbody) tx_crc <= vfe_pkg::crc_byte(tx_crc, body);
            k <= k + 3'd1;
            if (tx_last) st <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            if (q.op == vfe_pkg::OP_RX) begin
              if (rx_take) begin
                rx_crc   <= rx_crc_n;
                rx_count <= rx_cnt_n;
                rx_match <= rx_match_n;
                vh       <= vh_n;
                vl       <= vl_n;
              end
              ov <= report;
              if (report) begin
                opay.kind         <= vfe_pkg::KIND_REPORT;
                opay.tx_byte      <= '0;
                opay.last         <= 1'b1;
                opay.crc_ok       <= (rx_crc_n == 16'h0000);
                opay.addr_ok      <= rx_match_n;
                opay.reply_value  <= {vh_n, vl_n};
              end
            end else begin
              // New request: set reply length, clear receiver, send address
              exp_len  <= (q.op == vfe_pkg::OP_READ) ? vfe_pkg::REPLY_LEN_READ
                        : (q.op == vfe_pkg::OP_SETF) ? vfe_pkg::REPLY_LEN_SETF
                        : vfe_pkg::REPLY_LEN_CTRL;
              rx_count <= '0;
              rx_crc   <= vfe_pkg::CRC_INIT;
              rx_match <= 1'b0;
              vh       <= '0;
              vl       <= '0;
              cur_op   <= q.op;
              freq     <= q.data;
              k        <= 3'd1;
              tx_crc   <= vfe_pkg::crc_byte(vfe_pkg::CRC_INIT, addr);
              ov                <= 1'b1;
              opay.kind         <= vfe_pkg::KIND_TX;
              opay.tx_byte      <= addr;
              opay.last         <= 1'b0;
              opay.crc_ok       <= 1'b0;
              opay.addr_ok      <= 1'b0;
              opay.reply_value  <= '0;
              st                <= ST_SEND;
            end
          end else if (load) begin
            ov <= 1'b0;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Terms for the checks
  assign req_pop = pop && (q.op != vfe_pkg::OP_RX);
  assign tx_end  = ov && (opay.kind == vfe_pkg::KIND_TX) && opay.last;
  assign idx_ok  = (k >= 3'd1) && (k <= nbody + 3'd1);

  // Checks
  `VFE_ASSERT(a_rx_count_bound, rx_count <= exp_len, "receive count passed reply length")
  `VFE_ASSERT_IMPL(a_tx_index, st == ST_SEND, idx_ok, "frame index out of range")
  `VFE_ASSERT_IMPL(a_last_ends_frame, tx_end, st == ST_IDLE, "busy after last frame byte")
  `VFE_ASSERT_NEXT(a_req_first_byte, req_pop, ov && opay.tx_byte == $past(addr), "bad first byte")

endmodule

FILE: rtl/vfd_modbus_frame_engine.sv
// ----------------------------------------------------------------------------
// vfd_modbus_frame_engine
// Frames drive requests with CRC-16 and checks the drive's replies.
//
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   func, speed_rpm, rx_byte
//   rsp      out  valid/ready   kind, tx_byte, last, crc_ok, addr_ok, reply_value
//   cfg      in   valid/ready   slave_address (always ready)
//
// A request gives six or seven frame bytes, one per cycle unless rsp stalls,
// the first in the cycle after it leaves the queue; the back-end sequencer
// sets that pace. Received bytes give a report on the final byte.
// Commands pass the front stage register and the queue to the back end.
// Reset (rst, synchronous) empties the queue and sets reply length 8, address 1.
// A stalled rsp holds the back end; the two-entry queue and front stage keep
// accepting until full.
// ----------------------------------------------------------------------------
module vfd_modbus_frame_engine (
  input  logic      clk,
  input  logic      rst,
  vfe_cmd_if.sink   cmd,
  vfe_rsp_if.source rsp,
  vfe_cfg_if.sink   cfg
);

  logic [7:0]        slave_address;
  vfe_pkg::q_entry_t f_ent;
  logic              f_valid;
  logic              f_ready;
  vfe_pkg::q_entry_t q_ent;
  logic              q_valid;
  logic              q_ready;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= vfe_pkg::SLAVE_ADDR_RST;
    end else if (cfg.valid) begin
      slave_address <= cfg.slave_address;
    end
  end

  vfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ent       (f_ent),
    .ent_valid (f_valid),
    .ent_ready (f_ready)
  );

  vfe_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .din      (f_ent),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .dout     (q_ent),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  vfe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q       (q_ent),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .addr    (slave_address),
    .rsp     (rsp)
  );

endmodule
